[rtl/core/box_blur_3x3_edge_shrink_top_defines.svh]
// ----------------------------------------------------------------------------
// box blur assertion macros
// check macros for the box blur block, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_EDGE_SHRINK_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_SHRINK_TOP_DEFINES_SVH

`ifndef SYNTH
// antecedent holds -> consequent holds in the same cycle
`define BB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("box blur check failed");
// antecedent holds -> consequent holds in the next cycle
`define BB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("box blur check failed");
`else
`define BB_ASSERT_NOW(lbl, ante, cons)
`define BB_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[rtl/core/bblur_pkg.sv]
// ----------------------------------------------------------------------------
// bblur_pkg
// shared types and constants of the 3x3 box blur
// ----------------------------------------------------------------------------
`default_nettype none

package bblur_pkg;

    // configuration
    localparam int          CFG_W         = 11;
    localparam int          MAX_WIDTH_DEF = 1024;
    localparam logic [10:0] WIDTH_RESET   = 11'd1024;

    // divider length: one quotient bit per step
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // item kinds
    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // one pixel, [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] rgb_t;

    typedef struct packed {
        logic       func;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last_of_run;
        logic       end_of_frame;
    } pix_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_INIT,
        ST_DIV,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic update;
        logic sum;
        logic init;
        logic step;
        logic pop;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic ignore;
        logic pend_any;
        logic more;
        logic div_last;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/bblur_ctrl.sv]
// ----------------------------------------------------------------------------
// bblur_ctrl
// sequencer: capture, window update, then per result sum, divide, hand off
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_ctrl import bblur_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  wire logic m_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // no input transaction is taken while reset is held
                s_ready     = aresetn;
                cmd.capture = s_valid;
                if (s_valid && !sts.ignore) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = sts.pend_any ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT: begin
                cmd.init   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.pop    = 1'b1;
                    state_next = sts.more ? ST_SUM : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/bblur_dp.sv]
// ----------------------------------------------------------------------------
// bblur_dp
// line stores, 3x3 window, position counters, window sum and divider
// ----------------------------------------------------------------------------
`default_nettype none

module bblur_dp import bblur_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire pix_in_t          s_payload,
    input  wire cmd_t             cmd,
    output sts_t                  sts,
    output pix_out_t              m_payload
);

    localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int XW     = ADDR_W + 1;
    localparam int CMP_W  = (XW > CFG_W) ? XW : CFG_W;

    // configuration and frame position
    logic [CFG_W-1:0]  width_reg;
    logic [ADDR_W-1:0] col_reg;
    logic [1:0]        rows_reg;
    logic              draining_reg;

    // captured item
    logic [ADDR_W-1:0] cur_col_reg;
    logic              cur_drain_reg;
    rgb_t              px_reg;

    // pending results and their window selection
    logic       pend1_reg;
    logic       pend2_reg;
    logic [1:0] first1_reg;
    logic [1:0] first2_reg;
    logic       top_reg;
    logic       eof_reg;

    // line stores and window
    rgb_t       upper_mem  [MAX_WIDTH];
    rgb_t       middle_mem [MAX_WIDTH];
    rgb_t       upper_rd_reg;
    rgb_t       middle_rd_reg;
    rgb_t       win_reg [3][3];
    logic [2:0] okb_reg;

    // sum and divider
    logic [11:0]       sum_reg [3];
    logic [3:0]        cnt_reg;
    logic [12:0]       num_reg [3];
    logic [12:0]       dsh_reg;
    logic [7:0]        q_reg [3];
    logic [STEP_W-1:0] step_reg;

    // combinational
    logic [CMP_W-1:0] wz;
    logic [CMP_W-1:0] effc;
    logic [XW-1:0]    eff_w;
    logic [XW-1:0]    col_inc;
    logic             last_col;
    logic             is_drain_in;
    logic             drain_now;
    logic             ignore;
    logic             rows_nz;
    logic [1:0]       first_sel;
    logic [2:0][2:0]  take;
    logic [9:0]       col_sum [3][3];
    logic [11:0]      tot [3];
    logic [3:0]       cnt;
    logic [3:0]       dvs;

    // width register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    // effective width: zero acts as one, clamp at the store depth
    always_comb begin
        wz = CMP_W'(width_reg);
        if (wz == '0) begin
            effc = CMP_W'(1);
        end else if (wz > CMP_W'(MAX_WIDTH)) begin
            effc = CMP_W'(MAX_WIDTH);
        end else begin
            effc = wz;
        end
        eff_w = XW'(effc);
    end

    // item classification and result decisions
    always_comb begin
        is_drain_in = (s_payload.func == FUNC_DRAIN);
        ignore      = is_drain_in && (rows_reg == 2'd0) && !draining_reg;
        drain_now   = is_drain_in || draining_reg;
        col_inc     = XW'(col_reg) + XW'(1);
        last_col    = (col_inc >= eff_w);
        rows_nz     = (rows_reg != 2'd0);
    end

    // frame position and pending results
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            rows_reg     <= 2'd0;
            draining_reg <= 1'b0;
            pend1_reg    <= 1'b0;
            pend2_reg    <= 1'b0;
        end else if (cmd.capture && !ignore) begin
            draining_reg <= drain_now && !last_col;
            pend1_reg    <= rows_nz && (col_reg != '0);
            pend2_reg    <= rows_nz && last_col;
            if (last_col) begin
                col_reg <= '0;
                if (drain_now) begin
                    rows_reg <= 2'd0;
                end else if (!rows_reg[1]) begin
                    rows_reg <= rows_reg + 2'd1;
                end
            end else begin
                col_reg <= col_inc[ADDR_W-1:0];
            end
        end else if (cmd.pop) begin
            if (pend1_reg) begin
                pend1_reg <= 1'b0;
            end else begin
                pend2_reg <= 1'b0;
            end
        end
    end

    // captured item fields
    always_ff @(posedge aclk) begin
        if (cmd.capture && !ignore) begin
            cur_col_reg   <= col_reg;
            cur_drain_reg <= drain_now;
            px_reg        <= rgb_t'({s_payload.red_in, s_payload.green_in, s_payload.blue_in});
            first1_reg    <= (XW'(col_reg) >= XW'(2)) ? 2'd0 : 2'd1;
            first2_reg    <= (col_reg != '0) ? 2'd1 : 2'd2;
            top_reg       <= rows_reg[1];
            eof_reg       <= drain_now;
        end
    end

    // upper line store: read on capture, takes the old middle entry on update
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            upper_rd_reg <= upper_mem[col_reg];
        end
        if (cmd.update && !cur_drain_reg) begin
            upper_mem[cur_col_reg] <= middle_rd_reg;
        end
    end

    // middle line store: read on capture, takes the new pixel on update
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            middle_rd_reg <= middle_mem[col_reg];
        end
        if (cmd.update && !cur_drain_reg) begin
            middle_mem[cur_col_reg] <= px_reg;
        end
    end

    // window shift, new column from the stores and the item
    always_ff @(posedge aclk) begin
        if (cmd.update) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= upper_rd_reg;
            win_reg[1][2] <= middle_rd_reg;
            win_reg[2][2] <= cur_drain_reg ? rgb_t'('0) : px_reg;
        end
    end

    // bottom row valid bits, one per window column
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            okb_reg <= 3'b000;
        end else if (cmd.update) begin
            okb_reg <= {~cur_drain_reg, okb_reg[2], okb_reg[1]};
        end
    end

    // window cells in use and their sums per channel
    always_comb begin
        first_sel = pend1_reg ? first1_reg : first2_reg;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                take[c][r] = (2'(c) >= first_sel) && ((r != 0) || top_reg)
                             && ((r != 2) || okb_reg[c]);
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int c = 0; c < 3; c++) begin
                col_sum[ch][c] = '0;
                for (int r = 0; r < 3; r++) begin
                    if (take[c][r]) begin
                        col_sum[ch][c] = col_sum[ch][c] + 10'(win_reg[r][c][ch]);
                    end
                end
            end
            tot[ch] = 12'(col_sum[ch][0]) + 12'(col_sum[ch][1]) + 12'(col_sum[ch][2]);
        end
        cnt = 4'(take[0][0]) + 4'(take[0][1]) + 4'(take[0][2])
            + 4'(take[1][0]) + 4'(take[1][1]) + 4'(take[1][2])
            + 4'(take[2][0]) + 4'(take[2][1]) + 4'(take[2][2]);
        dvs = (cnt_reg == 4'd0) ? 4'd1 : cnt_reg;
    end

    // sum register
    always_ff @(posedge aclk) begin
        if (cmd.sum) begin
            for (int ch = 0; ch < 3; ch++) begin
                sum_reg[ch] <= tot[ch];
            end
            cnt_reg <= cnt;
        end
    end

    // restoring divider: (2*sum + d) / (2*d), one quotient bit per step
    always_ff @(posedge aclk) begin
        if (cmd.init) begin
            for (int ch = 0; ch < 3; ch++) begin
                num_reg[ch] <= {sum_reg[ch], 1'b0} + 13'(dvs);
            end
            dsh_reg  <= 13'({dvs, 8'b0});
            step_reg <= '0;
        end else if (cmd.step) begin
            for (int ch = 0; ch < 3; ch++) begin
                if (num_reg[ch] >= dsh_reg) begin
                    num_reg[ch] <= num_reg[ch] - dsh_reg;
                    q_reg[ch]   <= {q_reg[ch][6:0], 1'b1};
                end else begin
                    q_reg[ch]   <= {q_reg[ch][6:0], 1'b0};
                end
            end
            dsh_reg  <= dsh_reg >> 1;
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    // status and result payload
    always_comb begin
        sts.ignore   = ignore;
        sts.pend_any = pend1_reg || pend2_reg;
        sts.more     = pend1_reg && pend2_reg;
        sts.div_last = (step_reg == STEP_W'(DIV_STEPS - 1));

        m_payload.red_out      = q_reg[2];
        m_payload.green_out    = q_reg[1];
        m_payload.blue_out     = q_reg[0];
        m_payload.last_of_run  = pend1_reg ? !pend2_reg : 1'b1;
        m_payload.end_of_frame = !pend1_reg && eof_reg;
    end

endmodule

`default_nettype wire

[rtl/core/box_blur_3x3_edge_shrink_top.sv]
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_shrink_top
// Streaming 3x3 box blur of RGB888 pixels in raster order. Each result is the
// per-channel mean of the pixel's neighborhood, rounded half up; at image
// borders only existing pixels count. Results lag the input by one row plus
// one pixel; after the last row send one drain transaction per column. Items
// are processed one at a time: a transaction is captured and shifted into the
// window, then each result it releases (0, 1 or 2) takes a window sum, a
// divider load, the 8-step restoring divider that runs all three channels in
// parallel, and a result handoff that waits for the output side; an ignored
// drain is dropped without a window update. The line stores have no clearing
// pass and are usable right after reset. Write image_width only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "box_blur_3x3_edge_shrink_top_defines.svh"

module box_blur_3x3_edge_shrink_top import bblur_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire pix_in_t          s_payload,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output pix_out_t              m_payload
);

    cmd_t cmd;
    sts_t sts;

    // sequencer
    bblur_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // stores, window and arithmetic
    bblur_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_payload   (s_payload),
        .cmd         (cmd),
        .sts         (sts),
        .m_payload   (m_payload)
    );

    // checks
    `BB_ASSERT_NOW(a_one_side, m_valid, !s_ready)
    `BB_ASSERT_NEXT(a_no_early_result, s_valid && s_ready, !m_valid)
    `BB_ASSERT_NEXT(a_second_result, m_valid && m_ready && sts.more, !s_ready && !m_valid)
    `BB_ASSERT_NOW(a_eof_last, m_valid && m_payload.end_of_frame, m_payload.last_of_run)

endmodule

`default_nettype wire

[test/box_blur_3x3_edge_shrink_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_shrink_top_tb
// Drives raster frames of RGB pixels, each closed by a row of drain
// transactions, into the 3x3 box blur. A scoreboard keeps its own copy of the
// line stores, window and frame counters, predicts every blurred pixel with
// its flags, and checks the results in order. Directed frames come first:
// extreme and out-of-range widths, rounding, early and stray drains, and a
// width cut in mid row. A wide frame and random frames follow under
// several idle and stall patterns.
// ----------------------------------------------------------------------------

module box_blur_3x3_edge_shrink_top_tb;
    import bblur_pkg::*;

    localparam int LIMIT_CYCLES      = 1_000_000;
    localparam int POST_IDLE_CYCLES  = 40;
    localparam int DRAIN_WAIT_CYCLES = 20_000;
    localparam int RANDOM_ITEMS      = 440;
    localparam int HOLDOFF_CYCLES    = 400;
    localparam int MAX_PRINTED       = 100;

    // scoreboard: blur predictor and store of expected pixels
    class blur_scoreboard;
        logic [CFG_W-1:0] width_reg;
        rgb_t             upper_line [MAX_WIDTH_DEF];
        rgb_t             middle_line [MAX_WIDTH_DEF];
        rgb_t             win [3][3];
        bit               below_ok [3];
        int unsigned      col;
        int unsigned      rows_seen;
        bit               draining;
        pix_out_t         expected_q [$];
        int               errors;
        int               results_seen;

        function new();
            width_reg    = WIDTH_RESET;
            col          = 0;
            rows_seen    = 0;
            draining     = 1'b0;
            errors       = 0;
            results_seen = 0;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[r, c]) win[r][c] = '0;
            foreach (below_ok[c]) below_ok[c] = 1'b0;
        endfunction

        // rounded-half-up mean over window columns first..2
        function pix_out_t window_mean(int first, bit top);
            int unsigned sum [3];
            int unsigned cnt;
            pix_out_t    res;
            sum = '{0, 0, 0};
            cnt = 0;
            for (int cc = first; cc < 3; cc++) begin
                for (int rr = 0; rr < 3; rr++) begin
                    if ((rr == 0 && !top) || (rr == 2 && !below_ok[cc])) continue;
                    for (int ch = 0; ch < 3; ch++) sum[ch] += win[rr][cc][ch];
                    cnt++;
                end
            end
            res = '0;
            res.red_out   = 8'((2 * sum[2] + cnt) / (2 * cnt));
            res.green_out = 8'((2 * sum[1] + cnt) / (2 * cnt));
            res.blue_out  = 8'((2 * sum[0] + cnt) / (2 * cnt));
            return res;
        endfunction

        // accepted input transaction: advance state, queue its results
        function void note_input(pix_in_t item);
            int unsigned w;
            int unsigned c;
            rgb_t        px;
            bit          drain;
            bit          top;
            bit          row_end;
            pix_out_t    res;
            if (width_reg == 0) w = 1;
            else if (width_reg > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
            else w = width_reg;
            c  = col;
            px = {item.red_in, item.green_in, item.blue_in};

            // drain with no full row behind it is dropped
            if (item.func == FUNC_DRAIN && rows_seen == 0 && !draining) return;
            if (item.func == FUNC_DRAIN) draining = 1'b1;
            drain = draining;

            // slide the window and pull in the new column
            for (int rr = 0; rr < 3; rr++) begin
                win[rr][0] = win[rr][1];
                win[rr][1] = win[rr][2];
            end
            below_ok[0] = below_ok[1];
            below_ok[1] = below_ok[2];
            win[0][2]   = upper_line[c];
            win[1][2]   = middle_line[c];
            win[2][2]   = drain ? '0 : px;
            below_ok[2] = !drain;
            if (!drain) begin
                upper_line[c]  = middle_line[c];
                middle_line[c] = px;
            end

            // results for the row above
            top     = rows_seen >= 2;
            row_end = c + 1 >= w;
            if (rows_seen >= 1) begin
                if (c >= 1) begin
                    res = window_mean((c >= 2) ? 0 : 1, top);
                    res.last_of_run = !row_end;
                    expected_q.push_back(res);
                end
                if (row_end) begin
                    res = window_mean((c >= 1) ? 1 : 2, top);
                    res.last_of_run  = 1'b1;
                    res.end_of_frame = drain;
                    expected_q.push_back(res);
                end
            end

            // column and row bookkeeping
            if (row_end) begin
                col = 0;
                if (drain) begin
                    rows_seen = 0;
                    draining  = 1'b0;
                end else if (rows_seen < 2) begin
                    rows_seen++;
                end
            end else begin
                col = c + 1;
            end
        endfunction

        task report_mismatch(string msg);
            if (errors < MAX_PRINTED) $display("mismatch: %s", msg);
            errors++;
        endtask

        task compare_field(string name, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s got %h want %h",
                                          results_seen, name, got, want));
        endtask

        // accepted result transaction against the oldest expectation
        task check_result(pix_out_t got);
            pix_out_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d with nothing expected: %h",
                                          results_seen, got));
            end else begin
                want = expected_q.pop_front();
                compare_field("red_out", got.red_out, want.red_out);
                compare_field("green_out", got.green_out, want.green_out);
                compare_field("blue_out", got.blue_out, want.blue_out);
                compare_field("last_of_run", got.last_of_run, want.last_of_run);
                compare_field("end_of_frame", got.end_of_frame, want.end_of_frame);
            end
            results_seen++;
        endtask
    endclass

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    pix_in_t          s_payload;
    logic             m_valid;
    logic             m_ready;
    pix_out_t         m_payload;

    int               src_idle_pct   = 0;
    int               sink_stall_pct = 0;
    int               sink_hold_req  = 0;
    int               items_sent     = 0;
    int               cycle_count    = 0;
    blur_scoreboard   sb;

    box_blur_3x3_edge_shrink_top dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // run limit
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // transaction monitor: inputs first so expectations exist before results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_input(s_payload);
            if (m_valid && m_ready) sb.check_result(m_payload);
        end
    end

    // result receiver: random stalls, plus long hold-offs on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold_req) @(negedge aclk);
                sink_hold_req = 0;
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pix_in_t pixel_item(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pix_in_t item;
        item.func     = FUNC_PIXEL;
        item.red_in   = r;
        item.green_in = g;
        item.blue_in  = b;
        return item;
    endfunction

    function automatic pix_in_t rand_pixel();
        return pixel_item(rand_chan(), rand_chan(), rand_chan());
    endfunction

    // drain with junk in the pixel fields
    function automatic pix_in_t drain_item();
        pix_in_t item;
        item      = pixel_item(8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)));
        item.func = FUNC_DRAIN;
        return item;
    endfunction

    function automatic logic [CFG_W-1:0] pick_width();
        case ($urandom_range(9))
            0: return '0;
            1: return CFG_W'(1);
            2: return CFG_W'($urandom_range(13, 40));
            default: return CFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    // offer one input transaction, with random idle gaps before it
    task automatic send_item(pix_in_t item);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender pauses until every expected result is in and the block is quiet
    task automatic wait_idle();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.expected_q.size() != 0 && waited < DRAIN_WAIT_CYCLES) begin
            @(negedge aclk);
            waited++;
        end
        repeat (POST_IDLE_CYCLES) @(negedge aclk);
    endtask

    task automatic change_width(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.width_reg = value;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 65; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 65; end
            default: begin src_idle_pct = 6; sink_stall_pct = 6; end
        endcase
    endtask

    // pixel rows then a drain row; sometimes the drain cuts into the last
    // pixel row, sometimes stray pixels sit inside the drain row
    task automatic send_frame(int w, int rows);
        int style;
        int cut;
        style = $urandom_range(5);
        cut   = (style == 0) ? $urandom_range(w - 1) : 0;
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < w; c++) send_item(rand_pixel());
        for (int c = 0; c < cut; c++) send_item(rand_pixel());
        send_item(drain_item());
        for (int c = cut + 1; c < w; c++)
            send_item((style == 1 && $urandom_range(2) == 0) ? rand_pixel() : drain_item());
        items_sent += rows * w + w;
    endtask

    // stimulus
    initial begin
        int               phase_start;
        logic [CFG_W-1:0] w_reg;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_payload   = '0;
        sb          = new();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: drain before any full row is dropped
        set_idling(3);
        send_item(drain_item());

        // width zero acts as one: every pixel is a row
        change_width('0);
        send_item(pixel_item(8'hFF, 8'hFF, 8'hFF));
        send_item(pixel_item(8'h00, 8'h00, 8'h00));
        send_item(pixel_item(8'hFF, 8'h00, 8'h80));
        send_item(drain_item());

        // two columns, extremes and half-way rounding
        change_width(CFG_W'(2));
        send_item(pixel_item(8'h01, 8'h00, 8'hFF));
        send_item(pixel_item(8'h00, 8'hFF, 8'h00));
        send_item(pixel_item(8'hFF, 8'hFF, 8'hFF));
        send_item(pixel_item(8'h00, 8'h00, 8'h01));
        send_item(drain_item());
        send_item(drain_item());

        // width cut in mid row, then a stray pixel inside the drain row
        change_width(CFG_W'(5));
        for (int c = 0; c < 8; c++) send_item(rand_pixel());
        change_width(CFG_W'(2));
        for (int c = 0; c < 3; c++) send_item(rand_pixel());
        send_item(drain_item());
        send_item(rand_pixel());

        // wide frame, drain in mid row with stray pixels after it
        change_width(CFG_W'(128));
        for (int c = 0; c < 132; c++) send_item(rand_pixel());
        send_item(drain_item());
        for (int c = 5; c < 128; c++)
            send_item(($urandom_range(3) == 0) ? rand_pixel() : drain_item());

        // random frames under each idle pattern
        items_sent = 0;
        for (int mode = 0; mode < 4; mode++) begin
            set_idling(mode);
            phase_start = items_sent;
            w_reg       = pick_width();
            change_width(w_reg);
            if (mode == 0) sink_hold_req = HOLDOFF_CYCLES;
            while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
                if ($urandom_range(3) == 0) begin
                    w_reg = pick_width();
                    change_width(w_reg);
                end
                // stray drain between frames, dropped by the block
                if ($urandom_range(4) == 0) send_item(drain_item());
                send_frame((w_reg == 0) ? 1 : int'(w_reg), $urandom_range(1, 4));
            end
        end

        // wind down
        wait_idle();
        if (sb.expected_q.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.expected_q.size()));
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/bblur_pkg.sv
rtl/core/bblur_ctrl.sv
rtl/core/bblur_dp.sv
rtl/core/box_blur_3x3_edge_shrink_top.sv
test/box_blur_3x3_edge_shrink_top_tb.sv
